@@ src/multilevel_feedback_queue_scheduler_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MFQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MFQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

@@ src/mfqs_pkg.sv @@
// Shared types, constants and command/status structs of the feedback queue scheduler.
package mfqs_pkg;

    // Default sizes
    localparam int DEF_LEVELS    = 4;
    localparam int DEF_MAX_JOBS  = 16;
    localparam int DEF_TIME_BITS = 16;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes
    localparam logic [2:0] REG_NUM_LEVELS   = 3'd0;
    localparam logic [2:0] REG_QUANTUM_0    = 3'd1;
    localparam logic [2:0] REG_QUANTUM_1    = 3'd2;
    localparam logic [2:0] REG_QUANTUM_2    = 3'd3;
    localparam logic [2:0] REG_QUANTUM_3    = 3'd4;
    localparam logic [2:0] REG_BOOST_PERIOD = 3'd5;

    // Register reset values
    localparam logic [2:0]  RST_NUM_LEVELS   = 3'd4;
    localparam logic [15:0] RST_QUANTUM_0    = 16'd2;
    localparam logic [15:0] RST_QUANTUM_1    = 16'd4;
    localparam logic [15:0] RST_QUANTUM_2    = 16'd8;
    localparam logic [15:0] RST_QUANTUM_3    = 16'd16;
    localparam logic [15:0] RST_BOOST_PERIOD = 16'd500;

    // Request types
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Outcome codes
    localparam logic [2:0] OUT_IDLE     = 3'd0;
    localparam logic [2:0] OUT_RAN      = 3'd1;
    localparam logic [2:0] OUT_FINISHED = 3'd2;
    localparam logic [2:0] OUT_DEMOTED  = 3'd3;
    localparam logic [2:0] OUT_REQUEUED = 3'd4;
    localparam logic [2:0] OUT_IO_YIELD = 3'd5;
    localparam logic [2:0] OUT_ADDED    = 3'd6;
    localparam logic [2:0] OUT_FULL     = 3'd7;

    typedef struct packed {
        logic        req_type;
        logic [15:0] job_need;
        logic        job_is_io;
    } req_t;

    typedef struct packed {
        logic [3:0]  job_id;
        logic [1:0]  job_level;
        logic [2:0]  outcome;
        logic        boosted;
        logic [15:0] remaining;
        logic [15:0] cpu_used;
    } res_t;

    typedef struct packed {
        logic [2:0]  num_levels;
        logic [15:0] quantum_0;
        logic [15:0] quantum_1;
        logic [15:0] quantum_2;
        logic [15:0] quantum_3;
        logic [15:0] boost_period;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic add;       // add a job, load result
        logic tick;      // latch job source, pop a queue if needed
        logic exec;      // one tick of work, load result
        logic bst_init;  // boost: requeue running job, clear levels and slices
        logic bst_read;  // boost: pop head of current level
        logic bst_skip;  // boost: current level empty, go on
        logic bst_move;  // boost: push popped slot at top level
        logic emit;      // present result next cycle
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bst_due;
        logic bst_done;
        logic bst_empty;
    } stat_t;

endpackage

@@ src/mfqs_regs.sv @@
// Configuration register file on an APB-style port.
module mfqs_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfqs_pkg::ADDR_W-1:0]   paddr,
    input  logic [mfqs_pkg::DATA_W-1:0]   pwdata,
    output logic [mfqs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mfqs_pkg::cfg_t                cfg
);

    mfqs_pkg::cfg_t cfg_reg;
    mfqs_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                mfqs_pkg::REG_NUM_LEVELS:   cfg_next.num_levels   = pwdata[2:0];
                mfqs_pkg::REG_QUANTUM_0:    cfg_next.quantum_0    = pwdata[15:0];
                mfqs_pkg::REG_QUANTUM_1:    cfg_next.quantum_1    = pwdata[15:0];
                mfqs_pkg::REG_QUANTUM_2:    cfg_next.quantum_2    = pwdata[15:0];
                mfqs_pkg::REG_QUANTUM_3:    cfg_next.quantum_3    = pwdata[15:0];
                mfqs_pkg::REG_BOOST_PERIOD: cfg_next.boost_period = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_levels   <= mfqs_pkg::RST_NUM_LEVELS;
            cfg_reg.quantum_0    <= mfqs_pkg::RST_QUANTUM_0;
            cfg_reg.quantum_1    <= mfqs_pkg::RST_QUANTUM_1;
            cfg_reg.quantum_2    <= mfqs_pkg::RST_QUANTUM_2;
            cfg_reg.quantum_3    <= mfqs_pkg::RST_QUANTUM_3;
            cfg_reg.boost_period <= mfqs_pkg::RST_BOOST_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            mfqs_pkg::REG_NUM_LEVELS:   prdata = 32'(cfg_reg.num_levels);
            mfqs_pkg::REG_QUANTUM_0:    prdata = 32'(cfg_reg.quantum_0);
            mfqs_pkg::REG_QUANTUM_1:    prdata = 32'(cfg_reg.quantum_1);
            mfqs_pkg::REG_QUANTUM_2:    prdata = 32'(cfg_reg.quantum_2);
            mfqs_pkg::REG_QUANTUM_3:    prdata = 32'(cfg_reg.quantum_3);
            mfqs_pkg::REG_BOOST_PERIOD: prdata = 32'(cfg_reg.boost_period);
            default:                    prdata = '0;
        endcase
    end

endmodule

@@ src/mfqs_ctrl.sv @@
// Sequencing state machine of the scheduler: add, tick, boost walk.
module mfqs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            req_type,
    input  mfqs_pkg::stat_t stat,
    output mfqs_pkg::cmd_t  cmd,
    output logic            busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_BRUN = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_BWR  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == mfqs_pkg::REQ_ADD)
                    begin
                        cmd.add  = 1'b1;
                        cmd.emit = 1'b1;
                    end
                    else
                    begin
                        cmd.tick   = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.bst_due)
                begin
                    state_next = S_BRUN;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BRUN:
            begin
                cmd.bst_init = 1'b1;
                state_next   = S_BRD;
            end
            S_BRD:
            begin
                if (stat.bst_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.bst_empty)
                begin
                    cmd.bst_skip = 1'b1;
                end
                else
                begin
                    cmd.bst_read = 1'b1;
                    state_next   = S_BWR;
                end
            end
            S_BWR:
            begin
                cmd.bst_move = 1'b1;
                state_next   = S_BRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/mfqs_dp.sv @@
// Datapath: job table, per-level slot queues in one memory, tick arithmetic, result register.
module mfqs_dp #(
    parameter int LEVELS    = mfqs_pkg::DEF_LEVELS,
    parameter int MAX_JOBS  = mfqs_pkg::DEF_MAX_JOBS,
    parameter int TIME_BITS = mfqs_pkg::DEF_TIME_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mfqs_pkg::req_t  req,
    input  mfqs_pkg::cfg_t  cfg,
    input  mfqs_pkg::cmd_t  cmd,
    output mfqs_pkg::stat_t stat,
    output logic            done,
    output mfqs_pkg::res_t  res
);

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVC_W  = $clog2(LEVELS + 1);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int DEPTH  = LEVELS * MAX_JOBS;
    localparam int ADR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Job table
    logic [MAX_JOBS-1:0]  valid_reg;
    logic [TIME_BITS-1:0] rem_reg [MAX_JOBS];
    logic [TIME_BITS-1:0] cpu_reg [MAX_JOBS];
    logic [TIME_BITS-1:0] slc_reg [MAX_JOBS];
    logic [LVL_W-1:0]     lvl_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0]  io_reg;

    // Queues
    logic [SLOT_W-1:0] fifo_mem [DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] head_reg [LEVELS];
    logic [SLOT_W-1:0] tail_reg [LEVELS];
    logic [CNT_W-1:0]  cnt_reg  [LEVELS];

    // Control registers
    logic              run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic              have_reg, have_next;
    logic              sel_mem_reg, sel_mem_next;
    logic [15:0]       bc_reg, bc_next;
    logic [LVC_W-1:0]  blvl_reg, blvl_next;
    logic              done_reg;
    mfqs_pkg::res_t    res_reg, res_next;

    // Queue access this cycle
    logic              push_en, pop_en;
    logic [LVL_W-1:0]  push_lvl, pop_lvl;
    logic [SLOT_W-1:0] push_slot;

    // Search results
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              any_queued;
    logic [LVL_W-1:0]  first_lvl;

    // Tick arithmetic
    logic [SLOT_W-1:0]    s;
    logic [LVL_W-1:0]     lv;
    logic [15:0]          qnt;
    logic [3:0]           nl;
    logic [3:0]           lv_up;
    logic [TIME_BITS-1:0] rem_new, cpu_new, slc_new, slc_wr;
    logic                 fin, expired, demote, yield;
    logic [2:0]           outc;
    logic [15:0]          bc_inc;
    logic [TIME_BITS-1:0] need_t;

    function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(MAX_JOBS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADR_W-1:0] adr(input logic [LVL_W-1:0] l,
                                             input logic [SLOT_W-1:0] p);
        return ADR_W'(l) * ADR_W'(MAX_JOBS) + ADR_W'(p);
    endfunction

    assign need_t = TIME_BITS'(req.job_need);

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Highest-priority non-empty level
    always_comb
    begin
        any_queued = 1'b0;
        first_lvl  = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                any_queued = 1'b1;
                first_lvl  = LVL_W'(l);
            end
        end
    end

    // One tick of work on slot s
    assign s = sel_mem_reg ? rd_data_reg : run_slot_reg;

    always_comb
    begin
        lv = lvl_reg[s];
        case (3'(lv))
            3'd0:    qnt = cfg.quantum_0;
            3'd1:    qnt = cfg.quantum_1;
            3'd2:    qnt = cfg.quantum_2;
            default: qnt = cfg.quantum_3;
        endcase
        if (qnt == '0)
        begin
            qnt = 16'd1;
        end
        nl = (cfg.num_levels == '0) ? 4'd1 : 4'(cfg.num_levels);
        if (nl > 4'(LEVELS))
        begin
            nl = 4'(LEVELS);
        end
        lv_up   = 4'(lv) + 4'd1;
        rem_new = (rem_reg[s] != '0) ? rem_reg[s] - 1'b1 : '0;
        cpu_new = (cpu_reg[s] != TIME_MAX) ? cpu_reg[s] + 1'b1 : cpu_reg[s];
        slc_new = (slc_reg[s] != TIME_MAX) ? slc_reg[s] + 1'b1 : slc_reg[s];
        fin     = (rem_new == '0);
        expired = !fin && (CMP_W'(slc_new) >= CMP_W'(qnt));
        demote  = expired && (lv_up < nl);
        yield   = !fin && !expired && io_reg[s];
        slc_wr  = expired ? '0 : slc_new;
        if (fin)
        begin
            outc = mfqs_pkg::OUT_FINISHED;
        end
        else if (demote)
        begin
            outc = mfqs_pkg::OUT_DEMOTED;
        end
        else if (expired)
        begin
            outc = mfqs_pkg::OUT_REQUEUED;
        end
        else if (yield)
        begin
            outc = mfqs_pkg::OUT_IO_YIELD;
        end
        else
        begin
            outc = mfqs_pkg::OUT_RAN;
        end
    end

    assign bc_inc = bc_reg + 16'd1;

    // Status
    assign stat.bst_due   = (bc_inc >= cfg.boost_period);
    assign stat.bst_done  = (blvl_reg == LVC_W'(LEVELS));
    assign stat.bst_empty = (cnt_reg[blvl_reg[LVL_W-1:0]] == '0);

    // Queue push/pop selection
    always_comb
    begin
        push_en   = 1'b0;
        push_lvl  = '0;
        push_slot = '0;
        pop_en    = 1'b0;
        pop_lvl   = '0;
        if (cmd.add && free_found)
        begin
            push_en   = 1'b1;
            push_slot = free_slot;
        end
        if (cmd.exec && have_reg && (expired || yield))
        begin
            push_en   = 1'b1;
            push_lvl  = demote ? LVL_W'(lv_up) : lv;
            push_slot = s;
        end
        if (cmd.bst_init && run_valid_reg)
        begin
            push_en   = 1'b1;
            push_slot = run_slot_reg;
        end
        if (cmd.bst_move)
        begin
            push_en   = 1'b1;
            push_slot = rd_data_reg;
        end
        if (cmd.tick && !run_valid_reg && any_queued)
        begin
            pop_en  = 1'b1;
            pop_lvl = first_lvl;
        end
        if (cmd.bst_read)
        begin
            pop_en  = 1'b1;
            pop_lvl = blvl_reg[LVL_W-1:0];
        end
    end

    // Queue memory
    always_ff @(posedge clk)
    begin
        if (push_en && (cnt_reg[push_lvl] != CNT_W'(MAX_JOBS)))
        begin
            fifo_mem[adr(push_lvl, tail_reg[push_lvl])] <= push_slot;
        end
        if (pop_en)
        begin
            rd_data_reg <= fifo_mem[adr(pop_lvl, head_reg[pop_lvl])];
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                if (pop_en && (pop_lvl == LVL_W'(l)))
                begin
                    head_reg[l] <= ptr_inc(head_reg[l]);
                end
                if (push_en && (push_lvl == LVL_W'(l)) && (cnt_reg[l] != CNT_W'(MAX_JOBS)))
                begin
                    tail_reg[l] <= ptr_inc(tail_reg[l]);
                    if (!(pop_en && (pop_lvl == LVL_W'(l))))
                    begin
                        cnt_reg[l] <= cnt_reg[l] + 1'b1;
                    end
                end
                else if (pop_en && (pop_lvl == LVL_W'(l)))
                begin
                    cnt_reg[l] <= cnt_reg[l] - 1'b1;
                end
            end
        end
    end

    // Slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.add && free_found)
            begin
                valid_reg[free_slot] <= 1'b1;
            end
            if (cmd.exec && have_reg && fin)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        if (cmd.add && free_found)
        begin
            rem_reg[free_slot] <= need_t;
            cpu_reg[free_slot] <= '0;
            slc_reg[free_slot] <= '0;
            lvl_reg[free_slot] <= '0;
            io_reg[free_slot]  <= req.job_is_io;
        end
        if (cmd.exec && have_reg)
        begin
            rem_reg[s] <= rem_new;
            cpu_reg[s] <= cpu_new;
            slc_reg[s] <= slc_wr;
            if (demote)
            begin
                lvl_reg[s] <= LVL_W'(lv_up);
            end
        end
        if (cmd.bst_init)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                lvl_reg[i] <= '0;
                slc_reg[i] <= '0;
            end
        end
    end

    // Control register next values
    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        have_next      = have_reg;
        sel_mem_next   = sel_mem_reg;
        bc_next        = bc_reg;
        blvl_next      = blvl_reg;
        res_next       = res_reg;
        if (cmd.tick)
        begin
            have_next    = run_valid_reg || any_queued;
            sel_mem_next = !run_valid_reg;
        end
        if (cmd.add)
        begin
            res_next = '0;
            if (free_found)
            begin
                res_next.job_id    = 4'(free_slot);
                res_next.outcome   = mfqs_pkg::OUT_ADDED;
                res_next.remaining = 16'(need_t);
            end
            else
            begin
                res_next.outcome = mfqs_pkg::OUT_FULL;
            end
        end
        if (cmd.exec)
        begin
            res_next         = '0;
            res_next.boosted = stat.bst_due;
            bc_next          = stat.bst_due ? 16'd0 : bc_inc;
            if (have_reg)
            begin
                run_slot_next      = s;
                run_valid_next     = (outc == mfqs_pkg::OUT_RAN);
                res_next.job_id    = 4'(s);
                res_next.job_level = 2'(lv);
                res_next.outcome   = outc;
                res_next.remaining = 16'(rem_new);
                res_next.cpu_used  = 16'(cpu_new);
            end
        end
        if (cmd.bst_init)
        begin
            run_valid_next = 1'b0;
            blvl_next      = LVC_W'(1);
        end
        if (cmd.bst_skip)
        begin
            blvl_next = blvl_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            have_reg      <= 1'b0;
            sel_mem_reg   <= 1'b0;
            bc_reg        <= '0;
            blvl_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            have_reg      <= have_next;
            sel_mem_reg   <= sel_mem_next;
            bc_reg        <= bc_next;
            blvl_reg      <= blvl_next;
            done_reg      <= cmd.emit;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ src/multilevel_feedback_queue_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler with priority boost.
//
//   channel   handshake               payload
//   request   start, busy             req   (mfqs_pkg::req_t)
//   result    done (one-cycle strobe) res   (mfqs_pkg::res_t)
//   config    psel/penable/pwrite     paddr, pwdata, prdata (6 registers at 4*i)
//
// An add item is taken while busy stays low; its result strobes on the next cycle.
// A tick reads the queue head, then does the update. A tick that boosts also walks the
// lower queues one pop and one push at a time through the single queue memory, moving
// each job up to the top level.
// Reset clears all control state; no clearing pass. Results cannot be stalled.
module multilevel_feedback_queue_scheduler #(
    parameter int LEVELS    = mfqs_pkg::DEF_LEVELS,
    parameter int MAX_JOBS  = mfqs_pkg::DEF_MAX_JOBS,
    parameter int TIME_BITS = mfqs_pkg::DEF_TIME_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mfqs_pkg::req_t              req,
    output logic                        done,
    output mfqs_pkg::res_t              res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfqs_pkg::ADDR_W-1:0] paddr,
    input  logic [mfqs_pkg::DATA_W-1:0] pwdata,
    output logic [mfqs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

`include "multilevel_feedback_queue_scheduler_macros.svh"

    mfqs_pkg::cfg_t  cfg;
    mfqs_pkg::cmd_t  cmd;
    mfqs_pkg::stat_t stat;

    mfqs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    mfqs_dp #(
        .LEVELS    (LEVELS),
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .res   (res)
    );

    // Checks
    `MFQS_ASSERT_NEXT(a_add_result, start && !busy && (req.req_type == mfqs_pkg::REQ_ADD), done && ((res.outcome == mfqs_pkg::OUT_ADDED) || (res.outcome == mfqs_pkg::OUT_FULL)))
    `MFQS_ASSERT_IMP(a_done_idle, done, !busy)
    `MFQS_ASSERT_IMP(a_full_zero, done && (res.outcome == mfqs_pkg::OUT_FULL), (res.job_id == '0) && (res.remaining == '0) && (res.cpu_used == '0))
    `MFQS_ASSERT_IMP(a_add_noboost, done && ((res.outcome == mfqs_pkg::OUT_ADDED) || (res.outcome == mfqs_pkg::OUT_FULL)), !res.boosted)

endmodule
